/* rtl/core/lpr_pkg.sv */
package lpr_pkg;

  // Fixed field widths of the stream ports.
  localparam int PAGE_W      = 16;
  localparam int FRAME_IDX_W = 3;
  localparam int COUNT_W     = 16;
  localparam int ACT_W       = 4;

  localparam logic [ACT_W-1:0]   ACT_RESET = ACT_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Widths of out_tdata and out_tuser.
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  // Outcome of one table lookup, handed from the frame table to the top level.
  typedef struct packed {
    logic                   is_hit;
    logic [FRAME_IDX_W-1:0] frame_index;
    logic                   evicted_valid;
    logic [PAGE_W-1:0]      evicted_page;
  } lpr_result_t;

endpackage

/* rtl/core/lpr_table.sv */
module lpr_table
  import lpr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [ACT_W-1:0]  active_frames,
  input  logic              req_valid,
  input  logic [PAGE_W-1:0] req_page,
  input  logic              req_last,
  output lpr_result_t       result
);

  localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int AW     = (CNT_W > ACT_W) ? CNT_W : ACT_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_FRAMES - 1);
  localparam logic [AW-1:0]     ACT_MAX  = AW'(MAX_FRAMES);

  logic [MAX_FRAMES-1:0] valid_r, valid_nxt;
  logic [PAGE_BITS-1:0]  page_r   [MAX_FRAMES];
  logic [RANK_W-1:0]     rank_r   [MAX_FRAMES];
  logic [RANK_W-1:0]     rank_nxt [MAX_FRAMES];

  logic [AW-1:0]         act;
  logic [MAX_FRAMES-1:0] act_mask;
  logic [PAGE_BITS-1:0]  page_q;
  logic                  hit;
  logic [IDX_W-1:0]      hit_idx;
  logic                  free_any;
  logic [IDX_W-1:0]      free_idx;
  logic                  vic_any;
  logic [IDX_W-1:0]      vic_idx;
  logic [RANK_W-1:0]     vic_rank;
  logic [IDX_W-1:0]      sel;
  logic                  ev_valid;
  logic [PAGE_BITS-1:0]  ev_page;

  // Zero frames behaves as one; values above the table size saturate.
  always_comb begin
    act = AW'(active_frames);
    if (act == '0) begin
      act = AW'(1);
    end else if (act > ACT_MAX) begin
      act = ACT_MAX;
    end
    for (int i = 0; i < MAX_FRAMES; i++) begin
      act_mask[i] = AW'(i) < act;
    end
  end

  always_comb begin
    for (int b = 0; b < PAGE_BITS; b++) begin
      page_q[b] = (b < PAGE_W) ? req_page[b] : 1'b0;
    end
  end

  // Lookup, free-frame search and victim search run side by side.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (act_mask[i] && valid_r[i] && page_r[i] == page_q) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (act_mask[i] && !valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // Oldest valid frame wins; a strict compare keeps the lowest index on ties.
  always_comb begin
    vic_any  = 1'b0;
    vic_idx  = '0;
    vic_rank = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (act_mask[i] && valid_r[i] && (!vic_any || rank_r[i] > vic_rank)) begin
        vic_any  = 1'b1;
        vic_idx  = IDX_W'(i);
        vic_rank = rank_r[i];
      end
    end
  end

  always_comb begin
    sel      = hit ? hit_idx : (free_any ? free_idx : vic_idx);
    ev_valid = !hit && !free_any;
    ev_page  = ev_valid ? page_r[sel] : '0;
  end

  // On a hit only frames younger than the hit frame age; on a miss all do.
  always_comb begin
    valid_nxt = valid_r;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (act_mask[i] && IDX_W'(i) != sel && valid_r[i] && rank_r[i] < RANK_MAX &&
          (!hit || rank_r[i] < rank_r[sel])) begin
        rank_nxt[i] = rank_r[i] + RANK_W'(1);
      end
    end
    rank_nxt[sel]  = '0;
    valid_nxt[sel] = 1'b1;
    if (req_last) begin
      valid_nxt = '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else if (req_valid) begin
      valid_r <= valid_nxt;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !hit) begin
      page_r[sel] <= page_q;
    end
  end

  always_comb begin
    result.is_hit        = hit;
    result.evicted_valid = ev_valid;
    for (int b = 0; b < FRAME_IDX_W; b++) begin
      result.frame_index[b] = (b < IDX_W) ? sel[b] : 1'b0;
    end
    for (int b = 0; b < PAGE_W; b++) begin
      result.evicted_page[b] = (b < PAGE_BITS) ? ev_page[b] : 1'b0;
    end
  end

endmodule

/* rtl/core/lru_page_replacement.sv */
// LRU page replacement unit. Each page reference on the input stream is looked
// up in a small fully associative frame table; a hit refreshes the frame's
// recency, a miss counts a fault and fills the lowest free frame or evicts the
// least recently used page. One result comes out per reference, in order, and
// one reference can be taken every clock cycle while the result output is not
// stalled: a reference is captured in an input register, the whole table
// lookup and update are done from that register, and the result sits in an
// output register. A reference with tlast set returns the table and the fault
// count to empty once its result is formed. active_frames may be changed only
// while the block is idle; no clearing pass is needed after reset.
module lru_page_replacement
  import lpr_pkg::*;
#(
  parameter int MAX_FRAMES = 8,
  parameter int PAGE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // active_frames
  input  logic                  cfg_tvalid,
  output logic                  cfg_tready,
  input  logic [ACT_W-1:0]      cfg_tdata,
  // [15:0] page_number
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [PAGE_W-1:0]     in_tdata,
  input  logic                  in_tlast,
  // [2:0] frame_index, [18:3] evicted_page, [34:19] fault_count, [39:35] zero
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // [0] is_hit, [1] evicted_valid
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast
);

  logic [ACT_W-1:0]   active_r;
  logic               in_valid_r;
  logic [PAGE_W-1:0]  in_page_r;
  logic               in_last_r;
  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic               out_last_r;
  logic [COUNT_W-1:0] fault_r, fault_nxt;
  logic [COUNT_W-1:0] fault_out;
  logic               advance;
  lpr_result_t        result;

  assign cfg_tready = 1'b1;
  assign advance    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACT_RESET;
    end else if (cfg_tvalid) begin
      active_r <= cfg_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_page_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  lpr_table #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_table (
    .clk           (clk),
    .rst_n         (rst_n),
    .active_frames (active_r),
    .req_valid     (advance),
    .req_page      (in_page_r),
    .req_last      (in_last_r),
    .result        (result)
  );

  // The reported count includes this reference; the stored total clears after
  // the last reference of a string.
  always_comb begin
    fault_out = fault_r;
    if (!result.is_hit && fault_r != COUNT_MAX) begin
      fault_out = fault_r + COUNT_W'(1);
    end
    fault_nxt = in_last_r ? '0 : fault_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (advance) begin
      fault_r <= fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {5'b0, fault_out, result.evicted_page, result.frame_index};
      out_user_r <= {result.evicted_valid, result.is_hit};
      out_last_r <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/core/lpr_checker.sv */
module lpr_checker
  import lpr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [OUT_USER_W-1:0] out_tuser,
  input logic                  out_tlast
);

  // A result that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // A hit never evicts and carries a zero evicted page.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tuser[1] && out_tdata[18:3] == '0)
    else $error("hit reported with an eviction");

  // A fault always leaves a nonzero running count.
  a_fault_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[34:19] != '0)
    else $error("fault with zero fault count");

  // Across an idle gap within a string, the count grows by at most one.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast ##1 !out_tvalid |=>
      !out_tvalid || out_tdata[34:19] == $past(out_tdata[34:19], 2) ||
      out_tdata[34:19] == $past(out_tdata[34:19], 2) + 16'd1 ||
      out_tdata[34:19] == 16'hFFFF)
    else $error("fault count jumped");

  // The result channel is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind lru_page_replacement lpr_checker u_lpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
